FILE: rtl/core/xdld_pkg.sv
// Shared types and constants for the x86 divide length decoder.
package xdld_pkg;

  localparam int unsigned MaxInsnBytes = 15;

  localparam logic [7:0] OP_SIZE   = 8'h66;
  localparam logic [7:0] ADDR_SIZE = 8'h67;
  localparam logic [7:0] PFX_LOCK  = 8'hF0;
  localparam logic [7:0] PFX_REPNE = 8'hF2;
  localparam logic [7:0] PFX_REP   = 8'hF3;
  localparam logic [7:0] PFX_ES    = 8'h26;
  localparam logic [7:0] PFX_CS    = 8'h2E;
  localparam logic [7:0] PFX_SS    = 8'h36;
  localparam logic [7:0] PFX_DS    = 8'h3E;
  localparam logic [7:0] PFX_FS    = 8'h64;
  localparam logic [7:0] PFX_GS    = 8'h65;
  localparam logic [7:0] OPC_GRP3B = 8'hF6;
  localparam logic [7:0] OPC_GRP3V = 8'hF7;
  localparam logic [3:0] REX_HI    = 4'h4;
  localparam logic [2:0] REG_DIV   = 3'd6;
  localparam logic [2:0] REG_IDIV  = 3'd7;
  localparam logic [2:0] RM_SIB    = 3'd4;
  localparam logic [2:0] RM_DISP   = 3'd5;
  localparam logic [1:0] MOD_NONE  = 2'd0;
  localparam logic [1:0] MOD_D8    = 2'd1;
  localparam logic [1:0] MOD_D32   = 2'd2;
  localparam logic [1:0] MOD_REG   = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PREFIX = 3'd1,
    PH_MODRM  = 3'd2,
    PH_SIB    = 3'd3,
    PH_DISP   = 3'd4
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] byte_count;
    logic       size_override;
    logic       wide_operand;
    logic       addr_override;
    logic       byte_opcode;
    logic [1:0] modrm_mod;
    logic [2:0] disp_left;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       first;
  } in_item_t;

  typedef struct packed {
    logic       is_div;
    logic [3:0] insn_length;
    logic [3:0] operand_width;
  } out_item_t;

endpackage

FILE: rtl/core/x86_div_length_decoder_unit.sv
// Top level of the streaming x86 DIV/IDIV length decoder.
//
// Code bytes enter on the in channel (valid/ready), one item per byte, with
// first marking the opening byte of an instruction. Each accepted byte is
// held in an input register; once the output buffer has room the decode
// step updates the per-instruction state and, at the last byte or the byte
// where the instruction is rejected, writes one result into a two-entry output
// buffer. Results leave on the out channel (valid/ready): is_div, insn_length
// and operand_width, all zero on a reject.
// Throughput: one byte per cycle, set by the decode step on the state
// register, while the output buffer has room. When the receiver stalls, the
// buffer absorbs up to two results; after that the decode step holds and
// in_ready drops until a result is taken.
// mode64 is written through cfg_wr_en/cfg_wr_data; the user must do so only
// while the block is idle, and the block has no check for this. Reset
// clears the decode state to idle, empties the input register and the output
// buffer, and sets mode64 to 1.
module x86_div_length_decoder_unit #(
  parameter int unsigned MAX_INSN_BYTES = xdld_pkg::MaxInsnBytes
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  xdld_pkg::in_item_t in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output xdld_pkg::out_item_t out_item
);
  import xdld_pkg::*;

  logic       mode64;
  logic       hold_valid;
  in_item_t   hold;
  dec_state_t st;
  dec_state_t st_next;
  logic       emit;
  out_item_t  res;
  logic       has_room;
  logic       fire;

  assign fire     = hold_valid && has_room;
  assign in_ready = !hold_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode64 <= 1'b1;
    end else if (cfg_wr_en) begin
      mode64 <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      st         <= '0;
    end else begin
      if (in_ready) hold_valid <= in_valid;
      if (fire) st <= st_next;
    end
  end

  xdld_decode #(
    .MAX_INSN_BYTES(MAX_INSN_BYTES)
  ) u_decode (
    .st       (st),
    .item     (hold),
    .mode64   (mode64),
    .st_next  (st_next),
    .emit     (emit),
    .res      (res)
  );

  xdld_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fire && emit),
    .wr_item  (res),
    .has_room (has_room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  a_emit_idles: assert property (@(posedge clk) disable iff (rst)
    fire && emit |=> st.phase == PH_IDLE)
    else $error("decoder not idle after result");

  a_emit_visible: assert property (@(posedge clk) disable iff (rst)
    fire && emit |=> out_valid)
    else $error("result lost after decode");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.is_div |-> out_item.insn_length == 4'd0 &&
    out_item.operand_width == 4'd0)
    else $error("rejected item carries nonzero fields");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.is_div |-> {1'b0, out_item.insn_length} <= 5'(MAX_INSN_BYTES))
    else $error("measured length exceeds limit");

endmodule

FILE: rtl/core/xdld_decode.sv
// Per-byte decode step: next decoder state and the optional result.
module xdld_decode #(
  parameter int unsigned MAX_INSN_BYTES = xdld_pkg::MaxInsnBytes
) (
  input  xdld_pkg::dec_state_t st,
  input  xdld_pkg::in_item_t   item,
  input  logic                 mode64,
  output xdld_pkg::dec_state_t st_next,
  output logic                 emit,
  output xdld_pkg::out_item_t  res
);
  import xdld_pkg::*;

  localparam logic [4:0] LIMIT = 5'(MAX_INSN_BYTES);

  dec_state_t s;
  logic       ok;
  logic       chk;
  logic [2:0] need;
  logic [2:0] disp;
  logic [7:0] c;

  function automatic logic is_legacy(input logic [7:0] b);
    return b == PFX_LOCK || b == PFX_REPNE || b == PFX_REP || b == PFX_ES ||
           b == PFX_CS || b == PFX_SS || b == PFX_DS || b == PFX_FS || b == PFX_GS;
  endfunction

  function automatic logic [2:0] disp_bytes(input logic [1:0] md, input logic base5);
    if (md == MOD_D32 || (md == MOD_NONE && base5)) return 3'd4;
    if (md == MOD_D8) return 3'd1;
    return 3'd0;
  endfunction

  always_comb begin
    c    = item.code_byte;
    s    = st;
    emit = 1'b0;
    ok   = 1'b0;
    chk  = 1'b0;
    need = 3'd0;
    disp = 3'd0;
    if (item.first) begin
      s       = '0;
      s.phase = PH_PREFIX;
    end
    if (s.phase != PH_IDLE) begin
      s.byte_count = s.byte_count + 4'd1;
      case (s.phase)
        PH_PREFIX: begin
          chk = 1'b1;
          if (c == OP_SIZE) begin
            s.size_override = 1'b1;
          end else if (c == ADDR_SIZE) begin
            if (!mode64) begin
              s.addr_override = 1'b1;
              emit = 1'b1;
              chk  = 1'b0;
            end
          end else if (is_legacy(c)) begin
            s.size_override = s.size_override;
          end else if (mode64 && c[7:4] == REX_HI) begin
            s.wide_operand = c[3];
          end else if (c == OPC_GRP3B || c == OPC_GRP3V) begin
            s.byte_opcode = (c == OPC_GRP3B);
            s.phase       = PH_MODRM;
          end else begin
            emit = 1'b1;
            chk  = 1'b0;
          end
          need = (s.phase == PH_PREFIX) ? 3'd2 : 3'd1;
        end
        PH_MODRM: begin
          if (c[5:3] != REG_DIV && c[5:3] != REG_IDIV) begin
            emit = 1'b1;
          end else if (c[7:6] == MOD_REG) begin
            emit = 1'b1;
            ok   = 1'b1;
          end else begin
            s.modrm_mod = c[7:6];
            if (c[2:0] == RM_SIB) begin
              s.phase = PH_SIB;
              chk     = 1'b1;
              need    = 3'd1 + ((c[7:6] == MOD_D8) ? 3'd1 :
                                ((c[7:6] == MOD_D32) ? 3'd4 : 3'd0));
            end else begin
              disp        = disp_bytes(c[7:6], c[2:0] == RM_DISP);
              s.disp_left = disp;
              if (disp == 3'd0) begin
                emit = 1'b1;
                ok   = 1'b1;
              end else begin
                s.phase = PH_DISP;
                chk     = 1'b1;
                need    = disp;
              end
            end
          end
        end
        PH_SIB: begin
          disp        = disp_bytes(s.modrm_mod, c[2:0] == RM_DISP);
          s.disp_left = disp;
          if (disp == 3'd0) begin
            emit = 1'b1;
            ok   = 1'b1;
          end else begin
            s.phase = PH_DISP;
            chk     = 1'b1;
            need    = disp;
          end
        end
        PH_DISP: begin
          s.disp_left = s.disp_left - 3'd1;
          if (s.disp_left == 3'd0) begin
            emit = 1'b1;
            ok   = 1'b1;
          end else begin
            chk  = 1'b1;
            need = s.disp_left;
          end
        end
        default: begin
          s.phase = PH_IDLE;
        end
      endcase
      if (chk && ({1'b0, s.byte_count} + {2'b00, need} > LIMIT)) begin
        emit = 1'b1;
        ok   = 1'b0;
      end
    end
    if (emit) begin
      s.phase = PH_IDLE;
    end
    st_next = s;
    if (ok) begin
      res.is_div        = 1'b1;
      res.insn_length   = s.byte_count;
      res.operand_width = s.byte_opcode ? 4'd1 :
                          (s.wide_operand ? 4'd8 : (s.size_override ? 4'd2 : 4'd4));
    end else begin
      res = '0;
    end
  end

endmodule

FILE: rtl/core/xdld_out_buf.sv
// Two-entry result buffer between the decode step and the output channel.
module xdld_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  xdld_pkg::out_item_t wr_item,
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output xdld_pkg::out_item_t out_item
);
  import xdld_pkg::*;

  out_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       rd_en;

  assign out_valid = (count != 2'd0);
  assign has_room  = (count != 2'd2);
  assign rd_en     = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 && !rd_en |-> !wr_en)
    else $error("result buffer overflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

  a_ptr_balance: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd1) |-> (wr_ptr != rd_ptr))
    else $error("result buffer pointers inconsistent");

endmodule

FILE: tb/tb_x86_div_length_decoder_unit.sv
// Self-checking testbench for the streaming x86 DIV/IDIV length decoder.
module tb_x86_div_length_decoder_unit;
  import xdld_pkg::*;

  localparam int SettleCycles = 6;
  localparam int TimeoutCycles = 600000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;
  logic in_valid;
  logic in_ready;
  in_item_t in_item;
  logic out_valid;
  logic out_ready;
  out_item_t out_item;

  x86_div_length_decoder_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  always #6 clk = ~clk;

  // decoder shadow state
  logic mode_q = 1'b1;
  phase_t cur_phase = PH_IDLE;
  logic [3:0] cur_count = '0;
  logic cur_osize = 1'b0;
  logic cur_rexw = 1'b0;
  logic cur_asize = 1'b0;
  logic cur_byteop = 1'b0;
  logic [1:0] cur_mod = '0;
  logic [2:0] cur_disp = '0;

  out_item_t pending_lengths[$];
  logic [7:0] insn_buf[$];

  int errors = 0;
  int n_bytes = 0;
  int n_results = 0;
  int n_div = 0;
  int tx_gap_max = 13;
  int rx_gap_max = 13;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic logic [2:0] disp_len(input logic [1:0] md, input logic base5);
    if (md == MOD_D32 || (md == MOD_NONE && base5)) return 3'd4;
    if (md == MOD_D8) return 3'd1;
    return 3'd0;
  endfunction

  function automatic logic is_skip_prefix(input logic [7:0] c);
    return c == PFX_LOCK || c == PFX_REPNE || c == PFX_REP || c == PFX_ES ||
           c == PFX_CS || c == PFX_SS || c == PFX_DS || c == PFX_FS || c == PFX_GS;
  endfunction

  // Advances the shadow decoder by one byte; returns 1 when a result is due.
  function automatic logic length_decode(input in_item_t it, output out_item_t res);
    logic [7:0] c;
    int need;
    logic done;
    logic ok;
    c = it.code_byte;
    need = 0;
    done = 1'b0;
    ok = 1'b0;
    res = '0;
    if (it.first) begin
      cur_phase = PH_PREFIX;
      cur_count = '0;
      cur_osize = 1'b0;
      cur_rexw = 1'b0;
      cur_asize = 1'b0;
      cur_byteop = 1'b0;
      cur_mod = '0;
      cur_disp = '0;
    end
    if (cur_phase == PH_IDLE) return 1'b0;
    cur_count = cur_count + 4'd1;
    case (cur_phase)
      PH_PREFIX: begin
        if (c == OP_SIZE) begin
          cur_osize = 1'b1;
        end else if (c == ADDR_SIZE) begin
          if (!mode_q) begin
            cur_asize = 1'b1;
            done = 1'b1;
          end
        end else if (is_skip_prefix(c)) begin
        end else if (mode_q && c[7:4] == REX_HI) begin
          cur_rexw = c[3];
        end else if (c == OPC_GRP3B || c == OPC_GRP3V) begin
          cur_byteop = (c == OPC_GRP3B);
          cur_phase = PH_MODRM;
        end else begin
          done = 1'b1;
        end
        need = (cur_phase == PH_PREFIX) ? 2 : 1;
      end
      PH_MODRM: begin
        if (c[5:3] != REG_DIV && c[5:3] != REG_IDIV) begin
          done = 1'b1;
        end else if (c[7:6] == MOD_REG) begin
          done = 1'b1;
          ok = 1'b1;
        end else begin
          cur_mod = c[7:6];
          if (c[2:0] == RM_SIB) begin
            cur_phase = PH_SIB;
            need = 1 + (c[7:6] == MOD_D8 ? 1 : (c[7:6] == MOD_D32 ? 4 : 0));
          end else begin
            cur_disp = disp_len(c[7:6], c[2:0] == RM_DISP);
            if (cur_disp == 0) begin
              done = 1'b1;
              ok = 1'b1;
            end else begin
              cur_phase = PH_DISP;
              need = cur_disp;
            end
          end
        end
      end
      PH_SIB: begin
        cur_disp = disp_len(cur_mod, c[2:0] == RM_DISP);
        if (cur_disp == 0) begin
          done = 1'b1;
          ok = 1'b1;
        end else begin
          cur_phase = PH_DISP;
          need = cur_disp;
        end
      end
      PH_DISP: begin
        cur_disp = cur_disp - 3'd1;
        if (cur_disp == 0) begin
          done = 1'b1;
          ok = 1'b1;
        end else begin
          need = cur_disp;
        end
      end
      default: begin
        cur_phase = PH_IDLE;
        return 1'b0;
      end
    endcase
    if (!done && int'(cur_count) + need > MaxInsnBytes) done = 1'b1;
    if (!done) return 1'b0;
    if (ok) begin
      res.is_div = 1'b1;
      res.insn_length = cur_count;
      res.operand_width = cur_byteop ? 4'd1 : (cur_rexw ? 4'd8 : (cur_osize ? 4'd2 : 4'd4));
    end
    cur_phase = PH_IDLE;
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic f);
    int gap;
    in_item_t it;
    out_item_t res;
    gap = $urandom_range(0, tx_gap_max);
    it.code_byte = b;
    it.first = f;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_bytes++;
    if (length_decode(it, res)) pending_lengths.push_back(res);
  endtask

  task automatic send_insn();
    foreach (insn_buf[i]) send_byte(insn_buf[i], i == 0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_lengths.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_mode64(input logic v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_q = v;
  endtask

  // Well-formed divide with random prefixes, operands and displacement,
  // with a few wrong opcodes and reg fields mixed in.
  task automatic build_insn();
    int npfx;
    logic [1:0] md;
    logic [2:0] rg;
    logic [2:0] rm;
    logic [7:0] sib;
    int ndisp;
    insn_buf.delete();
    npfx = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 14) : $urandom_range(0, 3);
    repeat (npfx) begin
      case ($urandom_range(0, 11))
        0: insn_buf.push_back(OP_SIZE);
        1: insn_buf.push_back(ADDR_SIZE);
        2: insn_buf.push_back(PFX_LOCK);
        3: insn_buf.push_back(PFX_REPNE);
        4: insn_buf.push_back(PFX_REP);
        5: insn_buf.push_back(PFX_ES);
        6: insn_buf.push_back(PFX_CS);
        7: insn_buf.push_back(PFX_SS);
        8: insn_buf.push_back(PFX_DS);
        9: insn_buf.push_back(PFX_FS);
        10: insn_buf.push_back(PFX_GS);
        default: insn_buf.push_back({REX_HI, 4'($urandom_range(0, 15))});
      endcase
    end
    if ($urandom_range(0, 9) == 0) insn_buf.push_back(8'($urandom_range(0, 255)));
    else insn_buf.push_back($urandom_range(0, 1) ? OPC_GRP3B : OPC_GRP3V);
    md = 2'($urandom_range(0, 3));
    rm = 3'($urandom_range(0, 7));
    rg = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(0, 7)) :
         ($urandom_range(0, 1) ? REG_DIV : REG_IDIV);
    insn_buf.push_back({md, rg, rm});
    sib = 8'($urandom_range(0, 255));
    if (md != MOD_REG && rm == RM_SIB) insn_buf.push_back(sib);
    ndisp = 0;
    if (md == MOD_D32) ndisp = 4;
    else if (md == MOD_D8) ndisp = 1;
    else if (md == MOD_NONE && (rm == RM_DISP || (rm == RM_SIB && sib[2:0] == RM_DISP)))
      ndisp = 4;
    repeat (ndisp) insn_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic test_divide_forms();
    insn_buf = '{OPC_GRP3V, {MOD_REG, REG_DIV, 3'd0}};
    send_insn();
    insn_buf = '{OPC_GRP3B, {MOD_REG, REG_IDIV, 3'd7}};
    send_insn();
    insn_buf = '{OP_SIZE, OPC_GRP3V, {MOD_NONE, REG_DIV, 3'd0}};
    send_insn();
    insn_buf = '{{REX_HI, 4'hF}, PFX_LOCK, OPC_GRP3V, {MOD_NONE, REG_IDIV, RM_SIB},
                 {2'd0, 3'd4, RM_SIB}};
    send_insn();
    insn_buf = '{{REX_HI, 4'h8}, {REX_HI, 4'h0}, OPC_GRP3V, {MOD_REG, REG_DIV, 3'd1}};
    send_insn();
    insn_buf = '{OPC_GRP3V, {MOD_D8, REG_DIV, RM_SIB}, {2'd3, 3'd1, RM_DISP}, 8'h80};
    send_insn();
    insn_buf = '{OPC_GRP3V, {MOD_REG, 3'd0, 3'd0}};
    send_insn();
    insn_buf = '{8'h00};
    send_insn();
    // stray byte with no instruction open
    send_byte(8'hFF, 1'b0);
    // a new first byte abandons the open prefix
    send_byte(OP_SIZE, 1'b1);
    insn_buf = '{OPC_GRP3B, {MOD_REG, REG_DIV, 3'd2}};
    send_insn();
  endtask

  task automatic test_legacy_mode();
    set_mode64(1'b0);
    send_byte(ADDR_SIZE, 1'b1);
    insn_buf = '{{REX_HI, 4'h8}, OPC_GRP3V, {MOD_REG, REG_DIV, 3'd0}};
    send_insn();
    // mode changes while a prefix is open; next byte sees the new mode
    set_mode64(1'b1);
    send_byte(PFX_LOCK, 1'b1);
    set_mode64(1'b0);
    send_byte(ADDR_SIZE, 1'b0);
    set_mode64(1'b1);
    insn_buf = '{ADDR_SIZE, OPC_GRP3V, {MOD_REG, REG_IDIV, 3'd0}};
    send_insn();
  endtask

  task automatic test_random_stream(input logic mode, input int n_items,
                                    input int tx_max, input int rx_max);
    int sent;
    int k;
    set_mode64(mode);
    tx_gap_max = tx_max;
    rx_gap_max = rx_max;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        build_insn();
        k = $urandom_range(0, 9);
        if (k == 0 && insn_buf.size() > 1)
          insn_buf = insn_buf[0:$urandom_range(0, insn_buf.size() - 2)];
        send_insn();
        sent += insn_buf.size();
        if (k == 1) repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          sent++;
        end
      end
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t due;
    if (!rst && out_valid && out_ready) begin
      if (pending_lengths.size() == 0) begin
        report_mismatch($sformatf("unexpected result is_div=%0d len=%0d width=%0d",
                                  out_item.is_div, out_item.insn_length,
                                  out_item.operand_width));
      end else begin
        due = pending_lengths.pop_front();
        if (out_item.is_div !== due.is_div)
          report_mismatch($sformatf("is_div %0d, want %0d", out_item.is_div, due.is_div));
        if (out_item.insn_length !== due.insn_length)
          report_mismatch($sformatf("insn_length %0d, want %0d",
                                    out_item.insn_length, due.insn_length));
        if (out_item.operand_width !== due.operand_width)
          report_mismatch($sformatf("operand_width %0d, want %0d",
                                    out_item.operand_width, due.operand_width));
        n_results++;
        if (due.is_div) n_div++;
      end
    end
  end

  initial begin : result_sink
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      n = $urandom_range(0, rx_gap_max);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_divide_forms();
    test_legacy_mode();
    test_random_stream(1'b1, 270, 13, 13);
    test_random_stream(1'b0, 270, 0, 0);
    test_random_stream(1'b1, 270, 3, 13);
    test_random_stream(1'b0, 270, 13, 2);
    test_random_stream(1'b1, 270, 0, 13);
    wait_drained();
    if (pending_lengths.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_lengths.size()));
    $display("Decoded %0d code bytes in both modes with random gaps on both channels.",
             n_bytes);
    $display("Checked %0d results: %0d divides measured, %0d rejected.",
             n_results, n_div, n_results - n_div);
    if (errors == 0) begin
      $display("tb_x86_div_length_decoder_unit OK");
    end else begin
      $display("tb_x86_div_length_decoder_unit NOT OK");
    end
    $finish;
  end

  initial begin
    #(12 * TimeoutCycles);
    $display("Timeout with %0d results outstanding", pending_lengths.size());
    $display("tb_x86_div_length_decoder_unit NOT OK");
    $finish;
  end

endmodule
